@@ src/rv32eu_pkg.sv @@
// shared types and codes for the rv32i execute unit
// operation item, result item, class, kind, funct3 and size codes
`timescale 1ns / 1ps

package rv32eu_pkg;

  // operation classes
  localparam logic [3:0] FUNC_BRANCH = 4'd0;
  localparam logic [3:0] FUNC_JAL    = 4'd1;
  localparam logic [3:0] FUNC_LUI    = 4'd2;
  localparam logic [3:0] FUNC_AUIPC  = 4'd3;
  localparam logic [3:0] FUNC_STORE  = 4'd4;
  localparam logic [3:0] FUNC_LOAD   = 4'd5;
  localparam logic [3:0] FUNC_ALUI   = 4'd6;
  localparam logic [3:0] FUNC_JALR   = 4'd7;
  localparam logic [3:0] FUNC_ALUR   = 4'd8;

  // result kinds
  localparam logic [1:0] KIND_BUS      = 2'd0;
  localparam logic [1:0] KIND_BRANCH   = 2'd1;
  localparam logic [1:0] KIND_MEM      = 2'd2;
  localparam logic [1:0] KIND_REDIRECT = 2'd3;

  // alu funct3
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SLL  = 3'd1;
  localparam logic [2:0] ALU_SLT  = 3'd2;
  localparam logic [2:0] ALU_SLTU = 3'd3;
  localparam logic [2:0] ALU_XOR  = 3'd4;
  localparam logic [2:0] ALU_SR   = 3'd5;
  localparam logic [2:0] ALU_OR   = 3'd6;
  localparam logic [2:0] ALU_AND  = 3'd7;

  // branch funct3
  localparam logic [2:0] BR_EQ  = 3'd0;
  localparam logic [2:0] BR_NE  = 3'd1;
  localparam logic [2:0] BR_LT  = 3'd4;
  localparam logic [2:0] BR_GE  = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;

  // access sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_RSVD = 2'd3;

  localparam logic [31:0] LINK_OFFSET = 32'd4;

  typedef struct packed {
    logic [3:0]  func;
    logic [2:0]  funct3;
    logic        alt_op;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
    logic [31:0] imm_value;
    logic [31:0] pc_value;
    logic [4:0]  station_tag;
    logic [4:0]  dest_reg;
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  tag_out;
    logic [31:0] bus_value;
    logic        taken;
    logic [31:0] redirect_pc;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic        mem_write;
    logic [1:0]  mem_size;
    logic        mem_signed;
    logic [4:0]  load_dest;
  } result_t;

  // alu control handed from the top level
  typedef struct packed {
    logic [2:0] funct3;
    logic       alt_op;
    logic       reg_form;
  } alu_ctrl_t;

endpackage

@@ src/rv32eu_alu.sv @@
// integer alu for register and immediate forms
// depends on rv32eu_pkg
`timescale 1ns / 1ps

module rv32eu_alu (
  input  rv32eu_pkg::alu_ctrl_t ctrl,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  output logic [31:0]           y
);
  import rv32eu_pkg::*;

  logic [4:0] sh;

  assign sh = b[4:0];

  always_comb begin
    case (ctrl.funct3)
      ALU_ADD:  y = (ctrl.reg_form && ctrl.alt_op) ? (a - b) : (a + b);
      ALU_SLL:  y = a << sh;
      ALU_SLT:  y = {31'd0, ($signed(a) < $signed(b))};
      ALU_SLTU: y = {31'd0, (a < b)};
      ALU_XOR:  y = a ^ b;
      ALU_SR:   y = ctrl.alt_op ? 32'($signed(a) >>> sh) : (a >> sh);
      ALU_OR:   y = a | b;
      ALU_AND:  y = a & b;
      default:  y = a & b;
    endcase
  end

endmodule

@@ src/rv32eu_branch.sv @@
// branch condition compare
// depends on rv32eu_pkg
`timescale 1ns / 1ps

module rv32eu_branch (
  input  logic [2:0]  funct3,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        taken
);
  import rv32eu_pkg::*;

  logic eq;
  logic lt_s;
  logic lt_u;

  assign eq   = (a == b);
  assign lt_s = ($signed(a) < $signed(b));
  assign lt_u = (a < b);

  always_comb begin
    case (funct3)
      BR_EQ:   taken = eq;
      BR_NE:   taken = !eq;
      BR_LT:   taken = lt_s;
      BR_GE:   taken = !lt_s;
      BR_LTU:  taken = lt_u;
      BR_GEU:  taken = !lt_u;
      default: taken = 1'b1; // reserved codes count as taken
    endcase
  end

endmodule

@@ src/rv32i_execute_unit.sv @@
// rv32i execute unit: input register, single-pass execute logic, result register
// an accepted item passes the input register and then the result register; its result
//   shows on res with done high for one cycle
// throughput: one item per cycle; busy stays low, the receiver cannot stall
// reset: synchronous active-high rst clears both valid flags, nothing in flight
// depends on rv32eu_pkg, rv32eu_alu, rv32eu_branch
`timescale 1ns / 1ps

module rv32i_execute_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rv32eu_pkg::op_t     op,
  output logic                done,
  output rv32eu_pkg::result_t res
);
  import rv32eu_pkg::*;

  // input stage
  logic      in_valid;
  op_t       in_op;

  // execute stage outputs
  alu_ctrl_t alu_ctrl;
  logic [31:0] alu_b;
  logic [31:0] alu_y;
  logic        br_taken;
  logic [31:0] ea_sum;     // rs1 + imm, shared by memory and jalr
  logic [31:0] link_value; // pc + 4
  logic [1:0]  size_code;
  result_t     res_next;

  // every cycle is free to take an item, no stall path exists
  assign busy = 1'b0;

  // input register: control cleared on reset, payload captured on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op <= op;
    end
  end

  // alu: immediate form takes imm as second operand (shift uses imm[4:0])
  assign alu_ctrl.funct3   = in_op.funct3;
  assign alu_ctrl.alt_op   = in_op.alt_op;
  assign alu_ctrl.reg_form = (in_op.func == FUNC_ALUR);
  assign alu_b = (in_op.func == FUNC_ALUR) ? in_op.rs2_value : in_op.imm_value;

  rv32eu_alu u_alu (
    .ctrl (alu_ctrl),
    .a    (in_op.rs1_value),
    .b    (alu_b),
    .y    (alu_y)
  );

  rv32eu_branch u_branch (
    .funct3 (in_op.funct3),
    .a      (in_op.rs1_value),
    .b      (in_op.rs2_value),
    .taken  (br_taken)
  );

  assign ea_sum     = in_op.rs1_value + in_op.imm_value;
  assign link_value = in_op.pc_value + LINK_OFFSET;
  // reserved size code folds onto word
  assign size_code  = (in_op.funct3[1:0] == SIZE_RSVD) ? SIZE_WORD : in_op.funct3[1:0];

  // result formatting; unused fields stay zero
  always_comb begin
    res_next             = '0;
    res_next.kind        = KIND_BUS;
    res_next.tag_out     = in_op.station_tag;
    case (in_op.func)
      FUNC_BRANCH: begin
        res_next.kind  = KIND_BRANCH;
        res_next.taken = br_taken;
      end
      FUNC_JAL: begin
        res_next.bus_value = link_value;
      end
      FUNC_LUI: begin
        res_next.bus_value = in_op.imm_value;
      end
      FUNC_AUIPC: begin
        res_next.bus_value = in_op.imm_value + in_op.pc_value;
      end
      FUNC_STORE: begin
        res_next.kind        = KIND_MEM;
        res_next.mem_address = ea_sum;
        res_next.mem_data    = in_op.rs2_value;
        res_next.mem_write   = 1'b1;
        res_next.mem_size    = size_code;
      end
      FUNC_LOAD: begin
        res_next.kind        = KIND_MEM;
        res_next.mem_address = ea_sum;
        res_next.mem_size    = size_code;
        res_next.mem_signed  = !in_op.funct3[2];
        res_next.load_dest   = in_op.dest_reg;
      end
      FUNC_ALUI, FUNC_ALUR: begin
        res_next.bus_value = alu_y;
      end
      FUNC_JALR: begin
        res_next.kind        = KIND_REDIRECT;
        res_next.bus_value   = link_value;
        res_next.redirect_pc = {ea_sum[31:1], 1'b0};
      end
      default: begin
        // undefined class: plain bus item with value zero
        res_next.bus_value = '0;
      end
    endcase
  end

  // result register: strobe for one cycle per item
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      res <= res_next;
    end
  end

  // every accepted item gives exactly one strobe, after the input and result registers
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done == ($past(start && !busy && !rst, 2) && !$past(rst)))
    else $error("done strobe does not match accepted item");

  // a redirect target is always halfword aligned
  a_redirect_aligned: assert property (@(posedge clk) disable iff (rst)
    (done && res.kind == KIND_REDIRECT) |-> !res.redirect_pc[0])
    else $error("jalr target has bit 0 set");

  // only memory items may request a write
  a_write_only_mem: assert property (@(posedge clk) disable iff (rst)
    (done && res.mem_write) |-> (res.kind == KIND_MEM))
    else $error("write request on non-memory item");

  // a store never carries a load destination or sign
  a_store_clean: assert property (@(posedge clk) disable iff (rst)
    (done && res.mem_write) |-> (res.load_dest == '0 && !res.mem_signed))
    else $error("store carries load fields");

endmodule

@@ test/rv32eu_result_checker.sv @@
// result checker for the rv32i execute unit: predicts each accepted item, compares results
// depends on rv32eu_pkg; counts failures and reports the number of results still owed
`timescale 1ns / 1ps

module rv32eu_result_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  rv32eu_pkg::op_t     op,
  input  logic                done,
  input  rv32eu_pkg::result_t res,
  output int                  fail_count,
  output int                  pending
);
  import rv32eu_pkg::*;

  result_t expected_q[$];
  int mismatches = 0;
  int owed = 0;

  assign fail_count = mismatches;
  assign pending = owed;

  function automatic logic [31:0] alu_value(logic [2:0] f3, logic alt, logic [31:0] a,
                                            logic [31:0] b, logic reg_form);
    logic [4:0] sh;
    logic [31:0] v;
    sh = b[4:0];
    case (f3)
      ALU_ADD:  v = (reg_form && alt) ? a - b : a + b;
      ALU_SLL:  v = a << sh;
      ALU_SLT:  v = {31'b0, $signed(a) < $signed(b)};
      ALU_SLTU: v = {31'b0, a < b};
      ALU_XOR:  v = a ^ b;
      ALU_SR: begin
        if (alt) v = $signed(a) >>> sh;
        else v = a >> sh;
      end
      ALU_OR:   v = a | b;
      default:  v = a & b;
    endcase
    return v;
  endfunction

  function automatic logic branch_taken(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
    case (f3)
      BR_EQ:   return a == b;
      BR_NE:   return a != b;
      BR_LT:   return $signed(a) < $signed(b);
      BR_GE:   return !($signed(a) < $signed(b));
      BR_LTU:  return a < b;
      BR_GEU:  return a >= b;
      default: return 1'b1;  // reserved conditions count as taken
    endcase
  endfunction

  function automatic logic [1:0] access_size(logic [2:0] f3);
    return (f3[1:0] == SIZE_RSVD) ? SIZE_WORD : f3[1:0];
  endfunction

  function automatic result_t exec_result(op_t o);
    result_t r;
    logic [31:0] sum;
    r = '0;
    r.kind = KIND_BUS;
    r.tag_out = o.station_tag;
    sum = o.rs1_value + o.imm_value;
    case (o.func)
      FUNC_BRANCH: begin
        r.kind = KIND_BRANCH;
        r.taken = branch_taken(o.funct3, o.rs1_value, o.rs2_value);
      end
      FUNC_JAL:   r.bus_value = o.pc_value + LINK_OFFSET;
      FUNC_LUI:   r.bus_value = o.imm_value;
      FUNC_AUIPC: r.bus_value = o.imm_value + o.pc_value;
      FUNC_STORE: begin
        r.kind = KIND_MEM;
        r.mem_address = sum;
        r.mem_data = o.rs2_value;
        r.mem_write = 1'b1;
        r.mem_size = access_size(o.funct3);
      end
      FUNC_LOAD: begin
        r.kind = KIND_MEM;
        r.mem_address = sum;
        r.mem_size = access_size(o.funct3);
        r.mem_signed = ~o.funct3[2];
        r.load_dest = o.dest_reg;
      end
      FUNC_ALUI: r.bus_value = alu_value(o.funct3, o.alt_op, o.rs1_value, o.imm_value, 1'b0);
      FUNC_JALR: begin
        r.kind = KIND_REDIRECT;
        r.bus_value = o.pc_value + LINK_OFFSET;
        r.redirect_pc = {sum[31:1], 1'b0};
      end
      FUNC_ALUR: r.bus_value = alu_value(o.funct3, o.alt_op, o.rs1_value, o.rs2_value, 1'b1);
      default: ;  // undefined classes give an empty bus value
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with none expected, tag %0d", res.tag_out);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(res.kind));
          check_field("tag_out", 32'(want.tag_out), 32'(res.tag_out));
          check_field("bus_value", want.bus_value, res.bus_value);
          check_field("taken", 32'(want.taken), 32'(res.taken));
          check_field("redirect_pc", want.redirect_pc, res.redirect_pc);
          check_field("mem_address", want.mem_address, res.mem_address);
          check_field("mem_data", want.mem_data, res.mem_data);
          check_field("mem_write", 32'(want.mem_write), 32'(res.mem_write));
          check_field("mem_size", 32'(want.mem_size), 32'(res.mem_size));
          check_field("mem_signed", 32'(want.mem_signed), 32'(res.mem_signed));
          check_field("load_dest", 32'(want.load_dest), 32'(res.load_dest));
        end
      end
      if (start && !busy) expected_q.push_back(exec_result(op));
      owed = expected_q.size();
    end
  end

endmodule

@@ test/rv32i_execute_unit_tb.sv @@
// testbench top for the rv32i execute unit: drives directed then random items
// depends on rv32eu_pkg, rv32i_execute_unit and rv32eu_result_checker
`timescale 1ns / 1ps

module rv32i_execute_unit_tb;
  import rv32eu_pkg::*;

  localparam int RANDOM_ITEMS   = 1725;
  localparam int QUIET_TAIL     = 200;   // final stretch driven back to back
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;     // margin for stray strobes after the last result

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  op_t     op = '0;
  logic    busy;
  logic    done;
  result_t res;
  int      fail_count;
  int      pending;
  int      quiet_cycles = 0;

  // 2 ns clock
  always #1 clk = ~clk;

  rv32i_execute_unit dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .op    (op),
    .done  (done),
    .res   (res)
  );

  // prediction and comparison live in the checker; it only watches the ports
  rv32eu_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .done       (done),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog: a long stretch with no item and no result means the block hung
  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("rv32i_execute_unit: mismatch");
      $finish;
    end
  end

  // present one item at the falling edge and hold it until the block takes it
  task automatic drive_op(input op_t o);
    @(negedge clk);
    start <= 1'b1;
    op <= o;
    do @(posedge clk); while (busy);
  endtask

  // drop start for a burst; the op bus carries junk the block must ignore
  task automatic idle_burst(input int cycles);
    logic [191:0] junk;
    @(negedge clk);
    start <= 1'b0;
    junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    op <= junk[$bits(op_t)-1:0];
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic op_t make_op(logic [3:0] func, logic [2:0] f3, logic alt,
                                  logic [31:0] a, logic [31:0] b, logic [31:0] imm,
                                  logic [31:0] pc);
    op_t o;
    o.func = func;
    o.funct3 = f3;
    o.alt_op = alt;
    o.rs1_value = a;
    o.rs2_value = b;
    o.imm_value = imm;
    o.pc_value = pc;
    o.station_tag = 5'($urandom_range(0, 31));
    o.dest_reg = 5'($urandom_range(0, 31));
    return o;
  endfunction

  // operand values leaning toward the corners of signed and unsigned compare
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'h7fff_ffff;
          3: return 32'h8000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1: return $urandom_range(0, 64);
      2: return -$urandom_range(1, 64);
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t random_op();
    op_t o;
    logic [11:0] short_imm;
    // mostly real classes, a few undefined ones so func bit 3 sees both values
    if ($urandom_range(0, 99) < 92) o.func = 4'($urandom_range(0, 8));
    else o.func = 4'($urandom_range(9, 15));
    o.funct3 = 3'($urandom_range(0, 7));
    o.alt_op = 1'($urandom_range(0, 1));
    o.rs1_value = pick_word();
    o.rs2_value = pick_word();
    // equal operands so eq/ne/ge conditions hit both outcomes
    if (o.func == FUNC_BRANCH && $urandom_range(0, 3) == 0) o.rs2_value = o.rs1_value;
    // immediates are usually sign-extended 12-bit values, sometimes anything
    short_imm = 12'($urandom);
    if ($urandom_range(0, 1)) o.imm_value = {{20{short_imm[11]}}, short_imm};
    else o.imm_value = pick_word();
    o.pc_value = $urandom_range(0, 3) == 0 ? pick_word() : {$urandom} & 32'hffff_fffc;
    o.station_tag = 5'($urandom_range(0, 31));
    o.dest_reg = 5'($urandom_range(0, 31));
    return o;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every branch condition including the reserved ones
    drive_op(make_op(FUNC_BRANCH, BR_EQ, 1'b0, 32'h1234_5678, 32'h1234_5678, 0, 0));
    drive_op(make_op(FUNC_BRANCH, BR_NE, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 0, 0));
    drive_op(make_op(FUNC_BRANCH, BR_LT, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
    drive_op(make_op(FUNC_BRANCH, BR_GE, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
    drive_op(make_op(FUNC_BRANCH, BR_LTU, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
    drive_op(make_op(FUNC_BRANCH, BR_GEU, 1'b0, 32'h0000_0000, 32'hffff_ffff, 0, 0));
    drive_op(make_op(FUNC_BRANCH, 3'd2, 1'b0, 32'h0, 32'h1, 0, 0));
    drive_op(make_op(FUNC_BRANCH, 3'd3, 1'b1, 32'h5, 32'h5, 0, 0));
    // link and upper-immediate forms, with address wrap
    drive_op(make_op(FUNC_JAL, 3'd0, 1'b0, 0, 0, 0, 32'hffff_fffc));
    drive_op(make_op(FUNC_LUI, 3'd7, 1'b1, 0, 0, 32'hffff_f000, 32'h0));
    drive_op(make_op(FUNC_AUIPC, 3'd0, 1'b0, 0, 0, 32'h8000_0000, 32'h8000_0004));
    drive_op(make_op(FUNC_JALR, 3'd0, 1'b0, 32'h7fff_ffff, 0, 32'h0000_0002, 32'hffff_fffc));
    // memory requests: reserved size, unsigned and signed loads
    drive_op(make_op(FUNC_STORE, 3'd3, 1'b0, 32'hffff_fff0, 32'hdead_beef, 32'h10, 0));
    drive_op(make_op(FUNC_LOAD, 3'd4, 1'b0, 32'h1000, 0, 32'hffff_ffff, 0));
    drive_op(make_op(FUNC_LOAD, 3'd7, 1'b0, 32'hffff_ffff, 0, 32'hffff_ffff, 0));
    drive_op(make_op(FUNC_LOAD, 3'd1, 1'b1, 32'h0, 32'hffff_ffff, 32'h7ff, 0));
    // alu-imm: addi ignores alt, shifts only use imm[4:0]
    drive_op(make_op(FUNC_ALUI, ALU_ADD, 1'b1, 32'h10, 32'hffff_ffff, 32'h5, 0));
    drive_op(make_op(FUNC_ALUI, ALU_SR, 1'b1, 32'h8000_0000, 0, 32'h0000_041f, 0));
    drive_op(make_op(FUNC_ALUI, ALU_SLL, 1'b0, 32'hffff_ffff, 0, 32'hffff_ffff, 0));
    // alu-reg: sub, arithmetic shift, both compares at the sign boundary
    drive_op(make_op(FUNC_ALUR, ALU_ADD, 1'b1, 32'h0, 32'h1, 0, 0));
    drive_op(make_op(FUNC_ALUR, ALU_SR, 1'b1, 32'hf000_0000, 32'hffff_ffe4, 0, 0));
    drive_op(make_op(FUNC_ALUR, ALU_SLT, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
    drive_op(make_op(FUNC_ALUR, ALU_SLTU, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
    // undefined classes
    drive_op(make_op(4'd15, 3'd7, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                     32'hffff_ffff));
    drive_op(make_op(4'd9, 3'd0, 1'b0, 32'h1, 32'h1, 32'h1, 32'h1));

    // random items with idle bursts; the tail runs back to back
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 9) == 0)
        idle_burst($urandom_range(1, 13));
      drive_op(random_op());
    end
    @(negedge clk);
    start <= 1'b0;

    // let the last results come out, then a short margin for stray strobes
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) $display("rv32i_execute_unit: match");
    else $display("rv32i_execute_unit: mismatch");
    $finish;
  end

endmodule
